FILE: rtl/core/bmv_pkg.sv
// shared constants, types and microcode rom of the block mean / variance unit
package bmv_pkg;

  localparam int BLOCK_LEN = 10;
  localparam int EFF_LEN   = (BLOCK_LEN < 1) ? 1 : BLOCK_LEN;

  localparam int SAMPLE_W = 8;
  localparam int LEN_W    = $clog2(EFF_LEN + 1);
  localparam int POS_W    = LEN_W;
  localparam int SUM_W    = $clog2(EFF_LEN * 255 + 1);
  localparam int SQ_W     = $clog2(EFF_LEN * 65025 + 1);
  localparam int NUM_W    = SQ_W + LEN_W;
  localparam int TSUM_W   = 40;
  localparam int TCNT_W   = 32;
  localparam int FRAC_W   = 8;

  localparam int MEAN_W = 16;
  localparam int VAR_W  = 24;
  localparam int GM_W   = 16;

  // divider: dividend is left aligned in DVD_W bits, DVS_W bit divisor
  localparam int DVD_W = TSUM_W + FRAC_W;
  localparam int DVS_W = TCNT_W;
  localparam int CNT_W = $clog2(DVD_W + 1);

  localparam int GM_BITS = DVD_W;

  // x * 256 / d as (x * ceil(2^(k+8) / d)) >> k, exact while x * (rounding error) < 2^k
  localparam int LEN2 = EFF_LEN * EFF_LEN;

  localparam int MEAN_K = SUM_W + $clog2(EFF_LEN);
  localparam longint unsigned MEAN_RCP_L =
    ((64'd1 << (MEAN_K + FRAC_W)) + 64'(EFF_LEN) - 64'd1) / 64'(EFF_LEN);
  localparam int MEAN_RCP_W  = $clog2(MEAN_RCP_L + 64'd1);
  localparam int MEAN_PROD_W = SUM_W + MEAN_RCP_W;
  localparam logic [MEAN_RCP_W-1:0] MEAN_RCP = MEAN_RCP_W'(MEAN_RCP_L);

  localparam int VAR_K = NUM_W + $clog2(LEN2);
  localparam longint unsigned VAR_RCP_L =
    ((64'd1 << (VAR_K + FRAC_W)) + 64'(LEN2) - 64'd1) / 64'(LEN2);
  localparam int VAR_RCP_W  = $clog2(VAR_RCP_L + 64'd1);
  localparam int VAR_PROD_W = NUM_W + VAR_RCP_W;
  localparam logic [VAR_RCP_W-1:0] VAR_RCP = VAR_RCP_W'(VAR_RCP_L);

  localparam logic [LEN_W-1:0]  LEN_VAL  = LEN_W'(EFF_LEN);
  localparam logic [POS_W-1:0]  POS_LAST = POS_W'(EFF_LEN - 1);

  localparam int PC_W     = 4;
  localparam int UC_DEPTH = 10;

  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [3:0] {
    ACT_NOP,
    ACT_ACCEPT,
    ACT_LD_GLOB,
    ACT_DIV,
    ACT_ST_MEAN,
    ACT_ST_VAR,
    ACT_ST_GLOB,
    ACT_MUL_SQ,
    ACT_MUL_SUM,
    ACT_EMIT
  } act_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NOT_END,
    COND_DIV_MORE,
    COND_OUT_FULL
  } cond_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    pc_t   target;
  } uword_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctl_t;

  localparam pc_t PC_IDLE = pc_t'(0);

  // jump to target when the condition holds, else fall through
  function automatic uword_t ucode(input pc_t pc);
    uword_t w;
    w = '{act: ACT_NOP, cond: COND_ALWAYS, target: PC_IDLE};
    case (pc)
      pc_t'(0):  w = '{act: ACT_ACCEPT,  cond: COND_NOT_END,  target: pc_t'(0)};
      pc_t'(1):  w = '{act: ACT_NOP,     cond: COND_OUT_FULL, target: pc_t'(1)};
      pc_t'(2):  w = '{act: ACT_ST_MEAN, cond: COND_NEVER,    target: PC_IDLE};
      pc_t'(3):  w = '{act: ACT_MUL_SQ,  cond: COND_NEVER,    target: PC_IDLE};
      pc_t'(4):  w = '{act: ACT_MUL_SUM, cond: COND_NEVER,    target: PC_IDLE};
      pc_t'(5):  w = '{act: ACT_ST_VAR,  cond: COND_NEVER,    target: PC_IDLE};
      pc_t'(6):  w = '{act: ACT_LD_GLOB, cond: COND_NEVER,    target: PC_IDLE};
      pc_t'(7):  w = '{act: ACT_DIV,     cond: COND_DIV_MORE, target: pc_t'(7)};
      pc_t'(8):  w = '{act: ACT_ST_GLOB, cond: COND_NEVER,    target: PC_IDLE};
      pc_t'(9):  w = '{act: ACT_EMIT,    cond: COND_ALWAYS,   target: PC_IDLE};
      default:   w = '{act: ACT_NOP,     cond: COND_ALWAYS,   target: PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/core/bmv_div.sv
// restoring divider, one quotient bit per cycle
module bmv_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bmv_pkg::div_ctl_t             ctl,
  input  logic [bmv_pkg::DVD_W-1:0]     dividend,
  input  logic [bmv_pkg::DVS_W-1:0]     divisor,
  input  logic [bmv_pkg::CNT_W-1:0]     nbits,
  output logic [bmv_pkg::DVD_W-1:0]     quotient,
  output logic                          more
);

  logic [bmv_pkg::DVS_W-1:0] rem_r, rem_nxt;
  logic [bmv_pkg::DVD_W-1:0] q_r, q_nxt;
  logic [bmv_pkg::DVS_W-1:0] dvs_r, dvs_nxt;
  logic [bmv_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [bmv_pkg::DVS_W:0]   trial;
  logic [bmv_pkg::DVS_W:0]   diff;
  logic                      ge;

  always_comb begin
    trial = {rem_r, q_r[bmv_pkg::DVD_W-1]};
    diff  = trial - {1'b0, dvs_r};
    ge    = trial >= {1'b0, dvs_r};
    rem_nxt = rem_r;
    q_nxt   = q_r;
    dvs_nxt = dvs_r;
    cnt_nxt = cnt_r;
    if (ctl.load) begin
      rem_nxt = '0;
      q_nxt   = dividend;
      dvs_nxt = divisor;
      cnt_nxt = nbits;
    end else if (ctl.step) begin
      // remainder stays below the divisor, so the top bit of the trial drops
      rem_nxt = ge ? diff[bmv_pkg::DVS_W-1:0] : trial[bmv_pkg::DVS_W-1:0];
      q_nxt   = {q_r[bmv_pkg::DVD_W-2:0], ge};
      cnt_nxt = cnt_r - bmv_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    dvs_r <= dvs_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign quotient = q_r;
  assign more     = cnt_r > bmv_pkg::CNT_W'(1);

endmodule

FILE: rtl/core/block_mean_variance_unit.sv
// block mean, block variance and running global mean of 8-bit samples
//
// Input channel in_valid/in_ready/in_sample: one unsigned sample per request.
// Samples are grouped into blocks of BLOCK_LEN; every request except the last
// of a block leaves in_ready high. On the last sample of a block the unit
// stops taking samples and works out one result on the out_ channel:
// block mean, block population variance and mean of all samples so far,
// each unsigned with 8 fraction bits, truncated. The global mean clamps to
// 0xffff if it outgrows 16 bits, which needs a saturated global count.
// A microcode sequencer forms the block mean in one step and the block
// variance in steps MUL_SQ, MUL_SUM and ST_VAR by reciprocal multiplication
// and runs the global mean through a restoring divider that yields one
// quotient bit per cycle.
// The result sits in an output register until out_ready takes it; if the
// previous result is still waiting at the next block end, the sequencer
// holds there and in_ready stays low until the output is taken.
// rst_n (synchronous, active low) clears all sums, counts and the sequencer;
// in_ready stays low during reset and comes up once reset is released.
module block_mean_variance_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bmv_pkg::SAMPLE_W-1:0]  in_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bmv_pkg::MEAN_W-1:0]    out_block_mean,
  output logic [bmv_pkg::VAR_W-1:0]     out_block_variance,
  output logic [bmv_pkg::GM_W-1:0]      out_global_mean
);

  bmv_pkg::pc_t   pc_r, pc_nxt;
  bmv_pkg::uword_t cw;
  logic           cond_true;
  logic           blk_end;

  logic [bmv_pkg::SUM_W-1:0]  sum_r, sum_nxt;
  logic [bmv_pkg::SQ_W-1:0]   sq_r, sq_nxt;
  logic [bmv_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic [bmv_pkg::TSUM_W-1:0] tsum_r, tsum_nxt;
  logic [bmv_pkg::TCNT_W-1:0] tcnt_r, tcnt_nxt;
  logic [bmv_pkg::NUM_W-1:0]  num_r, num_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [bmv_pkg::MEAN_W-1:0] mean_r, mean_nxt;
  logic [bmv_pkg::VAR_W-1:0]  var_r, var_nxt;
  logic [bmv_pkg::GM_W-1:0]   gm_r, gm_nxt;

  logic [2*bmv_pkg::SAMPLE_W-1:0] smp_sq;
  logic [bmv_pkg::TSUM_W:0]       tsum_inc;
  logic [2*bmv_pkg::SUM_W-1:0]    sum_sq;
  logic [bmv_pkg::NUM_W-1:0]      len_sq;
  logic [bmv_pkg::MEAN_PROD_W-1:0] mean_prod;
  logic [bmv_pkg::VAR_PROD_W-1:0]  var_prod;

  bmv_pkg::div_ctl_t          div_ctl;
  logic [bmv_pkg::DVD_W-1:0]  div_dvd;
  logic [bmv_pkg::DVS_W-1:0]  div_dvs;
  logic [bmv_pkg::CNT_W-1:0]  div_bits;
  logic [bmv_pkg::DVD_W-1:0]  div_q;
  logic                       div_more;

  bmv_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .nbits    (div_bits),
    .quotient (div_q),
    .more     (div_more)
  );

  // sequencer
  always_comb begin
    cw       = bmv_pkg::ucode(pc_r);
    in_ready = rst_n && (cw.act == bmv_pkg::ACT_ACCEPT);
    blk_end  = in_valid && (pos_r == bmv_pkg::POS_LAST);
    case (cw.cond)
      bmv_pkg::COND_NEVER:    cond_true = 1'b0;
      bmv_pkg::COND_ALWAYS:   cond_true = 1'b1;
      bmv_pkg::COND_NOT_END:  cond_true = !blk_end;
      bmv_pkg::COND_DIV_MORE: cond_true = div_more;
      bmv_pkg::COND_OUT_FULL: cond_true = out_valid_r;
      default:                cond_true = 1'b0;
    endcase
    pc_nxt = cond_true ? cw.target : pc_r + bmv_pkg::pc_t'(1);
  end

  // datapath
  always_comb begin
    smp_sq    = in_sample * in_sample;
    tsum_inc  = {1'b0, tsum_r} + (bmv_pkg::TSUM_W+1)'(in_sample);
    sum_sq    = sum_r * sum_r;
    len_sq    = bmv_pkg::NUM_W'(bmv_pkg::LEN_VAL) * bmv_pkg::NUM_W'(sq_r);
    mean_prod = bmv_pkg::MEAN_PROD_W'(sum_r) * bmv_pkg::MEAN_PROD_W'(bmv_pkg::MEAN_RCP);
    var_prod  = bmv_pkg::VAR_PROD_W'(num_r) * bmv_pkg::VAR_PROD_W'(bmv_pkg::VAR_RCP);

    sum_nxt  = sum_r;
    sq_nxt   = sq_r;
    pos_nxt  = pos_r;
    tsum_nxt = tsum_r;
    tcnt_nxt = tcnt_r;
    num_nxt  = num_r;
    mean_nxt = mean_r;
    var_nxt  = var_r;
    gm_nxt   = gm_r;
    out_valid_nxt = out_valid_r && !out_ready;

    div_ctl  = '{load: 1'b0, step: 1'b0};
    div_dvd  = {tsum_r, bmv_pkg::FRAC_W'(0)};
    div_dvs  = tcnt_r;
    div_bits = bmv_pkg::CNT_W'(bmv_pkg::GM_BITS);

    case (cw.act)
      bmv_pkg::ACT_ACCEPT: begin
        if (in_valid) begin
          sum_nxt  = sum_r + bmv_pkg::SUM_W'(in_sample);
          sq_nxt   = sq_r + bmv_pkg::SQ_W'(smp_sq);
          pos_nxt  = blk_end ? '0 : pos_r + bmv_pkg::POS_W'(1);
          tsum_nxt = tsum_inc[bmv_pkg::TSUM_W] ? '1 : tsum_inc[bmv_pkg::TSUM_W-1:0];
          tcnt_nxt = (tcnt_r == '1) ? tcnt_r : tcnt_r + bmv_pkg::TCNT_W'(1);
        end
      end
      bmv_pkg::ACT_LD_GLOB: begin
        div_ctl.load = 1'b1;
      end
      bmv_pkg::ACT_DIV: begin
        div_ctl.step = 1'b1;
      end
      bmv_pkg::ACT_ST_MEAN: begin
        mean_nxt = mean_prod[bmv_pkg::MEAN_K +: bmv_pkg::MEAN_W];
      end
      bmv_pkg::ACT_ST_VAR: begin
        var_nxt = var_prod[bmv_pkg::VAR_K +: bmv_pkg::VAR_W];
      end
      bmv_pkg::ACT_ST_GLOB: begin
        // quotient only exceeds 16 bits after the count has saturated
        gm_nxt = (|div_q[bmv_pkg::DVD_W-1:bmv_pkg::GM_W]) ? '1
                 : div_q[bmv_pkg::GM_W-1:0];
      end
      bmv_pkg::ACT_MUL_SQ: begin
        num_nxt = len_sq;
      end
      bmv_pkg::ACT_MUL_SUM: begin
        num_nxt = num_r - bmv_pkg::NUM_W'(sum_sq);
      end
      bmv_pkg::ACT_EMIT: begin
        out_valid_nxt = 1'b1;
        sum_nxt = '0;
        sq_nxt  = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= bmv_pkg::PC_IDLE;
      sum_r       <= '0;
      sq_r        <= '0;
      pos_r       <= '0;
      tsum_r      <= '0;
      tcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      sum_r       <= sum_nxt;
      sq_r        <= sq_nxt;
      pos_r       <= pos_nxt;
      tsum_r      <= tsum_nxt;
      tcnt_r      <= tcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r  <= num_nxt;
    mean_r <= mean_nxt;
    var_r  <= var_nxt;
    gm_r   <= gm_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_block_mean     = mean_r;
  assign out_block_variance = var_r;
  assign out_global_mean    = gm_r;

  // a new result always starts from cleared block sums
  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (sum_r == '0) && (sq_r == '0) && (pos_r == '0))
    else $error("block sums not cleared at result");

  // the last sample of a block stops intake for the divisions
  a_end_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (pos_r == bmv_pkg::POS_LAST)) |=> !in_ready)
    else $error("intake continued past block end");

  // the division runs only while no result is pending, as do the writes of the output registers
  a_div_idle_out: assert property (@(posedge clk) disable iff (!rst_n)
    (cw.act == bmv_pkg::ACT_DIV) |-> !out_valid_r)
    else $error("division running while result pending");

endmodule
